// ----- hw/rtl/tsac_pkg.sv -----
// Shared types and constants for the two-way set-associative cache core.
// Depends on nothing; tsac_meta, the top level and the checker refer to it by scoped names.
`default_nettype none

package tsac_pkg;

  // Address split: byte offset, set index, tag.
  localparam int ADDR_W   = 32;
  localparam int OFFSET_W = 4;
  localparam int SETS     = 64;
  localparam int SET_W    = $clog2(SETS);
  localparam int TAG_W    = ADDR_W - OFFSET_W - SET_W;

  // One line is two 64-bit words.
  localparam int WORD_W = 64;
  localparam int LINE_W = 2 * WORD_W;

  // Packed widths of the stream beats.
  localparam int IN_DATA_W  = ADDR_W + 2 * WORD_W;
  localparam int OUT_DATA_W = ((LINE_W + OFFSET_W + 7) / 8) * 8;

  // Command carried in the input tuser bit.
  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_FILL   = 1'b1
  } cmd_t;

  // One way of one set as held in a way RAM.
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [LINE_W-1:0] line;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Valid and recency bits of the set under compare.
  typedef struct packed {
    logic valid0;
    logic valid1;
    logic recent;
  } meta_t;

  // Update of the valid and recency bits at the end of a compare.
  typedef struct packed {
    logic             we;
    logic             fill;
    logic             way;
    logic [SET_W-1:0] set;
  } meta_upd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tsac_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing; read-during-write to one address returns the old contents.
`default_nettype none

module tsac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds while rd_en is low.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tsac_meta.sv -----
// Valid bits of both ways and the most-recently-used way of each set, in flops.
// Depends on tsac_pkg; reset clears every bit so no clearing pass is needed.
`default_nettype none

module tsac_meta (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [tsac_pkg::SET_W-1:0] rd_set,
  output tsac_pkg::meta_t               meta,
  input  wire tsac_pkg::meta_upd_t      upd
);

  logic [tsac_pkg::SETS-1:0] valid0_r;
  logic [tsac_pkg::SETS-1:0] valid1_r;
  logic [tsac_pkg::SETS-1:0] recent_r;

  // Read the set under compare.
  always_comb begin
    meta.valid0 = valid0_r[rd_set];
    meta.valid1 = valid1_r[rd_set];
    meta.recent = recent_r[rd_set];
  end

  // A hit or a fill marks its way recent; a fill also sets the way's valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid0_r <= '0;
      valid1_r <= '0;
      recent_r <= '0;
    end else if (upd.we) begin
      recent_r[upd.set] <= upd.way;
      if (upd.fill && !upd.way) begin
        valid0_r[upd.set] <= 1'b1;
      end
      if (upd.fill && upd.way) begin
        valid1_r[upd.set] <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/two_way_set_assoc_cache_core.sv -----
// Top level of the two-way set-associative cache core with LRU replacement.
// Depends on tsac_pkg, tsac_ram (one per way) and tsac_meta.
//
// The cache takes one lookup or fill beat per clock while the output is not stalled
// and returns exactly one result beat per input beat, through the compare stage
// registers and the output register. The first step reads the addressed set from
// both way RAMs at acceptance; the second compares both tags, picks the way, writes
// a fill back and loads the output register. The rate of one beat per cycle is set
// by the single read and single write port of each way RAM; a fill followed at once
// by an access to the same set is served by forwarding the written entry. Valid and
// recency bits sit in flops cleared by reset, so the cache is usable from reset on.
`default_nettype none

module two_way_set_assoc_cache_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // in_tdata, from bit 0: address[31:0], fill_data_low[63:0], fill_data_high[63:0]
  input  wire logic [tsac_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: command (0 lookup, 1 fill)
  input  wire logic                            in_tuser,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // out_tdata, from bit 0: line_low[63:0], line_high[63:0], line_offset[3:0], zero pad
  output logic [tsac_pkg::OUT_DATA_W-1:0]      out_tdata,
  // out_tuser: hit
  output logic                                 out_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready
);

  localparam int AW = tsac_pkg::ADDR_W;
  localparam int OW = tsac_pkg::OFFSET_W;
  localparam int SW = tsac_pkg::SET_W;
  localparam int TW = tsac_pkg::TAG_W;
  localparam int WW = tsac_pkg::WORD_W;
  localparam int LW = tsac_pkg::LINE_W;

  // Input field split.
  logic [AW-1:0] in_addr;
  logic [LW-1:0] in_fill;
  logic          in_acc;

  assign in_addr = in_tdata[AW-1:0];
  assign in_fill = in_tdata[AW+LW-1:AW];

  // Compare stage registers.
  logic                 s1_v_r;
  tsac_pkg::cmd_t       s1_cmd_r;
  logic [TW-1:0]        s1_tag_r;
  logic [SW-1:0]        s1_set_r;
  logic [OW-1:0]        s1_off_r;
  logic [LW-1:0]        s1_fill_r;
  logic                 s1_go;

  // Output register.
  logic                 out_v_r;
  logic                 out_v_nxt;
  logic                 out_hit_r;
  logic [LW-1:0]        out_line_r;
  logic [OW-1:0]        out_off_r;

  // Forwarding of the last written entry.
  logic                 fw_v_r;
  logic [SW-1:0]        fw_set_r;
  logic                 fw_way_r;
  tsac_pkg::entry_t     fw_ent_r;

  // Handshake: the compare stage moves on when the output register is free.
  assign s1_go     = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_go;
  assign in_acc    = in_tvalid && in_tready;

  // Capture the accepted beat for the compare stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r  <= tsac_pkg::cmd_t'(in_tuser);
      s1_off_r  <= in_addr[OW-1:0];
      s1_set_r  <= in_addr[OW+SW-1:OW];
      s1_tag_r  <= in_addr[AW-1:OW+SW];
      s1_fill_r <= in_fill;
    end
  end

  // Way RAMs, read at acceptance, written when a fill leaves the compare stage.
  logic [tsac_pkg::ENTRY_W-1:0] ram_q0;
  logic [tsac_pkg::ENTRY_W-1:0] ram_q1;
  logic                         wr_en;
  logic                         wr_way;
  tsac_pkg::entry_t             wr_ent;

  tsac_ram #(
    .WIDTH (tsac_pkg::ENTRY_W),
    .DEPTH (tsac_pkg::SETS)
  ) u_way0_ram (
    .clk     (clk),
    .wr_en   (wr_en && !wr_way),
    .wr_addr (s1_set_r),
    .wr_data (wr_ent),
    .rd_en   (in_acc),
    .rd_addr (in_addr[OW+SW-1:OW]),
    .rd_data (ram_q0)
  );

  tsac_ram #(
    .WIDTH (tsac_pkg::ENTRY_W),
    .DEPTH (tsac_pkg::SETS)
  ) u_way1_ram (
    .clk     (clk),
    .wr_en   (wr_en && wr_way),
    .wr_addr (s1_set_r),
    .wr_data (wr_ent),
    .rd_en   (in_acc),
    .rd_addr (in_addr[OW+SW-1:OW]),
    .rd_data (ram_q1)
  );

  // Valid and recency bits.
  tsac_pkg::meta_t     meta;
  tsac_pkg::meta_upd_t upd;

  tsac_meta u_meta (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_set (s1_set_r),
    .meta   (meta),
    .upd    (upd)
  );

  // The RAM read missed a write to the same set in the cycle it was issued.
  tsac_pkg::entry_t ent0;
  tsac_pkg::entry_t ent1;

  always_comb begin
    ent0 = tsac_pkg::entry_t'(ram_q0);
    ent1 = tsac_pkg::entry_t'(ram_q1);
    if (fw_v_r && fw_set_r == s1_set_r && !fw_way_r) begin
      ent0 = fw_ent_r;
    end
    if (fw_v_r && fw_set_r == s1_set_r && fw_way_r) begin
      ent1 = fw_ent_r;
    end
  end

  // Tag compare and way choice.
  logic          hit0;
  logic          hit1;
  logic          is_fill;
  logic          lk_hit;
  logic          fill_way;
  logic [LW-1:0] hit_line;

  assign hit0    = meta.valid0 && ent0.tag == s1_tag_r;
  assign hit1    = meta.valid1 && ent1.tag == s1_tag_r;
  assign is_fill = s1_cmd_r == tsac_pkg::CMD_FILL;
  assign lk_hit  = !is_fill && (hit0 || hit1);
  // Way 0 wins when both ways match.
  assign hit_line = hit0 ? ent0.line : ent1.line;

  // Fill victim: an invalid way first, way 0 before way 1, else the older way.
  always_comb begin
    priority if (!meta.valid0) begin
      fill_way = 1'b0;
    end else if (!meta.valid1) begin
      fill_way = 1'b1;
    end else begin
      fill_way = !meta.recent;
    end
  end

  assign wr_en      = s1_go && is_fill;
  assign wr_way     = fill_way;
  assign wr_ent.tag  = s1_tag_r;
  assign wr_ent.line = s1_fill_r;

  always_comb begin
    upd.we   = s1_go && (is_fill || lk_hit);
    upd.fill = is_fill;
    upd.way  = is_fill ? fill_way : !hit0;
    upd.set  = s1_set_r;
  end

  // Remember the last RAM write for the next compare.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_v_r <= 1'b0;
    end else if (s1_go) begin
      fw_v_r <= is_fill;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fw_set_r <= s1_set_r;
      fw_way_r <= fill_way;
      fw_ent_r <= wr_ent;
    end
  end

  // Output register.
  always_comb begin
    if (s1_go) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_hit_r  <= lk_hit;
      out_line_r <= lk_hit ? hit_line : '0;
      out_off_r  <= s1_off_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {{(tsac_pkg::OUT_DATA_W - LW - OW){1'b0}}, out_off_r,
                       out_line_r[LW-1:WW], out_line_r[WW-1:0]};

endmodule

`default_nettype wire

// ----- hw/rtl/tsac_checker.sv -----
// Port-level checks for the cache core, attached to the top level by a bind.
// Depends on tsac_pkg and two_way_set_assoc_cache_core.
`default_nettype none

module tsac_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [tsac_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                            out_tuser,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready
);

  // Beats accepted but not yet delivered.
  logic [1:0] occ_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 2'd0;
    end else if (in_acc && !out_acc) begin
      occ_r <= occ_r + 2'd1;
    end else if (!in_acc && out_acc) begin
      occ_r <= occ_r - 2'd1;
    end
  end

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // A miss or a fill carries zero line data.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[2*tsac_pkg::WORD_W-1:0] == '0)
    else $error("nonzero line data without a hit");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // No result without an accepted input beat.
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> occ_r != 2'd0)
    else $error("result beat without a pending input beat");

  // At most the compare stage and the output register hold beats.
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == 2'd2 |-> !in_tready || out_acc)
    else $error("input accepted while two beats are pending");

endmodule

bind two_way_set_assoc_cache_core tsac_checker u_tsac_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the two-way set-associative cache core with LRU replacement.
// Depends on tsac_pkg and two_way_set_assoc_cache_core; a scoreboard class predicts each
// reply beat from its own image of the tags, lines, valid and recency bits.

module testbench;
  import tsac_pkg::*;

  localparam int RANDOM_BEATS = 1900;
  localparam int FILLED_KEEP  = 24;

  // One expected reply beat.
  typedef struct {
    logic                hit;
    logic [WORD_W-1:0]   lo;
    logic [WORD_W-1:0]   hi;
    logic [OFFSET_W-1:0] offset;
  } cache_reply_t;

  // Predicts the cache replies and compares them with what comes out.
  class cache_scoreboard;
    logic [TAG_W-1:0]  way_tag [2*SETS];
    logic [WORD_W-1:0] way_lo  [2*SETS];
    logic [WORD_W-1:0] way_hi  [2*SETS];
    bit                way_vld [2*SETS];
    bit                mru_way [SETS];
    cache_reply_t      expected_replies[$];
    int mismatches, lookups, hits, fills, evictions, replies;

    function new();
      foreach (way_vld[i]) way_vld[i] = 1'b0;
      foreach (mru_way[i]) mru_way[i] = 1'b0;
    endfunction

    // Works out the reply to one accepted request and updates the cache image.
    function void note_request(cmd_t cmd, logic [ADDR_W-1:0] addr,
                               logic [WORD_W-1:0] fill_lo, logic [WORD_W-1:0] fill_hi);
      int           set_idx;
      int           slot;
      bit           victim;
      logic [TAG_W-1:0] tag;
      cache_reply_t r;
      set_idx  = int'(addr[OFFSET_W +: SET_W]);
      tag      = addr[ADDR_W-1 -: TAG_W];
      r.hit    = 1'b0;
      r.lo     = '0;
      r.hi     = '0;
      r.offset = addr[OFFSET_W-1:0];
      if (cmd == CMD_LOOKUP) begin
        lookups++;
        // Way 0 wins when both ways hold the tag.
        slot = -1;
        if (way_vld[2*set_idx] && way_tag[2*set_idx] == tag) slot = 2*set_idx;
        else if (way_vld[2*set_idx+1] && way_tag[2*set_idx+1] == tag) slot = 2*set_idx + 1;
        if (slot >= 0) begin
          hits++;
          r.hit = 1'b1;
          r.lo  = way_lo[slot];
          r.hi  = way_hi[slot];
          mru_way[set_idx] = slot[0];
        end
      end else begin
        fills++;
        // An empty way is taken first, way 0 before way 1; otherwise the older way.
        if (!way_vld[2*set_idx]) victim = 1'b0;
        else if (!way_vld[2*set_idx+1]) victim = 1'b1;
        else begin
          victim = ~mru_way[set_idx];
          evictions++;
        end
        slot          = 2*set_idx + victim;
        way_tag[slot] = tag;
        way_lo[slot]  = fill_lo;
        way_hi[slot]  = fill_hi;
        way_vld[slot] = 1'b1;
        mru_way[set_idx] = victim;
      end
      expected_replies.push_back(r);
    endfunction

    // Compares one reply beat with the oldest prediction.
    function void check_reply(logic hit, logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi,
                              logic [OFFSET_W-1:0] offset);
      cache_reply_t e;
      replies++;
      if (expected_replies.size() == 0) begin
        mismatches++;
        $error("reply beat arrived with no request outstanding");
        return;
      end
      e = expected_replies.pop_front();
      if (hit !== e.hit) begin
        mismatches++;
        $error("hit: expected %0d, actual %0d", e.hit, hit);
      end
      if (lo !== e.lo) begin
        mismatches++;
        $error("line_low: expected %h, actual %h", e.lo, lo);
      end
      if (hi !== e.hi) begin
        mismatches++;
        $error("line_high: expected %h, actual %h", e.hi, hi);
      end
      if (offset !== e.offset) begin
        mismatches++;
        $error("line_offset: expected %0d, actual %0d", e.offset, offset);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tvalid;
  logic                  out_tready;

  cache_scoreboard       sb;
  int                    beats_sent;
  logic [ADDR_W-1:0]     filled_addrs[$];
  logic [SET_W-1:0]      hot_sets[4];
  logic [TAG_W-1:0]      tag_pool[10];
  int                    rx_mode;
  int                    rx_left;

  two_way_set_assoc_cache_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  // Clock with a 2 ns period.
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Hard stop in case the core hangs.
  initial begin
    #1_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // The receiver switches between always ready, random stalls and two fixed patterns.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(40, 250);
    end else begin
      rx_left = rx_left - 1;
    end
    case (rx_mode)
      0: begin
        out_tready <= 1'b1;
      end
      1: begin
        out_tready <= ($urandom_range(0, 9) < 6);
      end
      2: begin
        out_tready <= (rx_left % 3) != 0;
      end
      default: begin
        out_tready <= (rx_left % 12) >= 9;
      end
    endcase
  end

  // Every accepted reply beat goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_reply(out_tuser, out_tdata[WORD_W-1:0], out_tdata[LINE_W-1:WORD_W],
                     out_tdata[LINE_W +: OFFSET_W]);
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Presents one request beat from a falling edge and holds it until accepted.
  task automatic send_beat(cmd_t cmd, logic [ADDR_W-1:0] addr,
                           logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {hi, lo, addr};
    do @(posedge clk); while (!in_tready);
    sb.note_request(cmd, addr, lo, hi);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic idle(int cycles);
    if (cycles > 0) begin
      in_tvalid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  // Holds off the sender until every outstanding reply has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.expected_replies.size() != 0) @(negedge clk);
  endtask

  // Mostly fills and lookups over a few hot sets and tags so that hits and evictions
  // are frequent, with some fully random addresses mixed in.
  task automatic send_random_beat();
    int                roll;
    logic [ADDR_W-1:0] addr;
    logic [SET_W-1:0]  set_idx;
    logic [TAG_W-1:0]  tag;
    roll = $urandom_range(0, 99);
    if (roll < 45 && filled_addrs.size() > 0) begin
      addr = filled_addrs[$urandom_range(0, filled_addrs.size() - 1)];
      addr[OFFSET_W-1:0] = OFFSET_W'($urandom_range(0, 15));
      send_beat(CMD_LOOKUP, addr, rand_word(), rand_word());
    end else if (roll < 55) begin
      send_beat(CMD_LOOKUP, $urandom, rand_word(), rand_word());
    end else begin
      set_idx = ($urandom_range(0, 9) < 7) ? hot_sets[$urandom_range(0, 3)]
                                            : SET_W'($urandom);
      tag     = ($urandom_range(0, 9) < 7) ? tag_pool[$urandom_range(0, 9)]
                                            : TAG_W'($urandom);
      addr    = {tag, set_idx, 4'($urandom_range(0, 15))};
      send_beat(CMD_FILL, addr, rand_word(), rand_word());
      filled_addrs.push_back(addr);
      if (filled_addrs.size() > FILLED_KEEP) void'(filled_addrs.pop_front());
    end
  endtask

  initial begin
    int burst;
    bit mid_drain;
    sb         = new();
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = CMD_LOOKUP;
    in_tdata   = '0;
    out_tready = 1'b0;
    mid_drain  = 1'b0;
    hot_sets[0] = '0;
    hot_sets[1] = '1;
    hot_sets[2] = SET_W'($urandom);
    hot_sets[3] = SET_W'($urandom);
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < 10; i++) tag_pool[i] = TAG_W'($urandom);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty cache, address extremes, LRU replacement in set 0, and
    // a tag that sits in both ways of set 1.
    send_beat(CMD_LOOKUP, 32'h0000_0000, rand_word(), rand_word());
    send_beat(CMD_LOOKUP, 32'hFFFF_FFFF, rand_word(), rand_word());
    send_beat(CMD_FILL,   32'h0000_0000, '1, '0);
    send_beat(CMD_FILL,   32'hFFFF_FFF0, '0, '1);
    send_beat(CMD_LOOKUP, 32'h0000_000F, '0, '0);
    send_beat(CMD_LOOKUP, 32'hFFFF_FFFF, '1, '1);
    send_beat(CMD_FILL,   32'h0000_0405, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
    send_beat(CMD_LOOKUP, 32'h0000_0400, '0, '0);
    send_beat(CMD_LOOKUP, 32'h0000_0003, '0, '0);
    send_beat(CMD_FILL,   32'h0000_0800, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_beat(CMD_LOOKUP, 32'h0000_0407, '0, '0);
    send_beat(CMD_LOOKUP, 32'h0000_080C, '0, '0);
    send_beat(CMD_LOOKUP, 32'h8000_0000, '0, '0);
    send_beat(CMD_FILL,   32'h0000_0010, 64'h1111_1111_1111_1111, 64'h2222_2222_2222_2222);
    send_beat(CMD_FILL,   32'h0000_0019, 64'h3333_3333_3333_3333, 64'h4444_4444_4444_4444);
    send_beat(CMD_LOOKUP, 32'h0000_001E, '0, '0);
    send_beat(CMD_FILL,   32'h0000_0010, 64'h5555_5555_0000_0000, 64'h6666_6666_0000_0000);
    send_beat(CMD_LOOKUP, 32'h0000_0011, '0, '0);
    send_beat(CMD_FILL,   32'h0000_0012, 64'h7777_0000_7777_0000, 64'h8888_0000_8888_0000);
    send_beat(CMD_LOOKUP, 32'h0000_0010, '0, '0);
    send_beat(CMD_LOOKUP, 32'h0000_0400, '0, '0);
    wait_drained();

    // Random bursts with random gaps; halfway through the sender drains the core.
    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      burst = $urandom_range(1, 32);
      repeat (burst) send_random_beat();
      if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 8));
      if (!mid_drain && beats_sent >= RANDOM_BEATS / 2) begin
        wait_drained();
        mid_drain = 1'b1;
      end
    end

    wait_drained();
    repeat (10) @(negedge clk);

    $display("Run covered %0d lookups (%0d hits) and %0d fills, %0d of them evicting",
             sb.lookups, sb.hits, sb.fills, sb.evictions);
    $display("a valid line, under bursty requests and a stalling reply side.");
    if (sb.mismatches == 0 && sb.expected_replies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
